// ===== src/fel_pkg.sv =====
package fel_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_INT,
        MODE_IDENT,
        MODE_STR,
        MODE_ESC,
        MODE_CMP,
        MODE_HALT
    } lex_mode_t;

    localparam logic [1:0] TT_INT   = 2'd0;
    localparam logic [1:0] TT_IDENT = 2'd1;
    localparam logic [1:0] TT_STR   = 2'd2;
    localparam logic [1:0] TT_OP    = 2'd3;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_CHAR     = 2'd1;
    localparam logic [1:0] ERR_STR_EOT  = 2'd2;
    localparam logic [1:0] ERR_OVERFLOW = 2'd3;

    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    localparam logic [34:0] INT_LIMIT = 35'h07FFFFFFF;

    typedef struct packed {
        logic [1:0]  token_type;
        logic [7:0]  token_char;
        logic        char_valid;
        logic        token_first;
        logic        token_end;
        logic [30:0] int_value;
        logic [1:0]  error_code;
        logic [15:0] error_position;
        logic        last_result;
    } lex_result_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic lex_result_t mk_res(
        input logic [1:0]  ttype,
        input logic [7:0]  ch,
        input logic        cv,
        input logic        first,
        input logic        tend,
        input logic [30:0] ival,
        input logic [1:0]  err,
        input logic [15:0] epos
    );
        lex_result_t r;
        r.token_type     = ttype;
        r.token_char     = ch;
        r.char_valid     = cv;
        r.token_first    = first;
        r.token_end      = tend;
        r.int_value      = ival;
        r.error_code     = err;
        r.error_position = epos;
        r.last_result    = 1'b0;
        return r;
    endfunction

    function automatic lex_result_t int_end_res(
        input logic [31:0] acc,
        input logic        ovf,
        input logic [15:0] ovf_pos
    );
        if (ovf)
        begin
            return mk_res(TT_INT, 8'd0, 1'b0, 1'b1, 1'b1, 31'd0, ERR_OVERFLOW, ovf_pos);
        end
        return mk_res(TT_INT, 8'd0, 1'b0, 1'b1, 1'b1, acc[30:0], ERR_NONE, 16'd0);
    endfunction

endpackage

// ===== src/filter_expression_lexer_core.sv =====
// Channel | Dir | Bits                                   | Transfer
// s_*     | in  | tdata[7:0] char, tlast end of text     | tvalid && tready
// m_*     | out | tdata 64b result, tuser 3b, tlast      | tvalid && tready
//
// One character is taken per cycle; its zero, one or two results are computed in
// the same cycle and written to a four-entry result queue, drained one per cycle.
// s_tready is high while the queue has two free entries, so a steady stream that
// yields one result per character runs at one character per cycle.
// Reset (rst_n low, asynchronous) clears the lexer state and empties the queue.
// A stall on m_tready backs up into s_tready once fewer than two queue entries are free.
module filter_expression_lexer_core #(
    parameter int POSITION_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_char
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [7:0] token_char, [8] token_first, [9] token_end,
                                   // [40:10] int_value, [42:41] error_code,
                                   // [58:43] error_position, [63:59] zero
    output logic [2:0]  m_tuser,   // [1:0] token_type, [2] char_valid
    output logic        m_tlast
);

    localparam logic [POSITION_BITS:0]   REP_MAX = (POSITION_BITS+1)'(17'h0FFFF);
    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    function automatic logic [15:0] rep_pos(input logic [POSITION_BITS-1:0] p);
        if ({1'b0, p} > REP_MAX)
        begin
            return 16'hFFFF;
        end
        return 16'(p);
    endfunction

    fel_pkg::lex_mode_t         mode_reg, mode_next;
    logic [31:0]                acc_reg, acc_next;
    logic                       ovf_reg, ovf_next;
    logic [15:0]                ovf_pos_reg, ovf_pos_next;
    logic                       sso_reg, sso_next;
    logic [POSITION_BITS-1:0]   pos_reg, pos_next;

    fel_pkg::lex_result_t       fifo_reg [4];
    logic [1:0]                 wr_ptr_reg, rd_ptr_reg;
    logic [2:0]                 count_reg;

    fel_pkg::lex_result_t       res_c [2];
    logic [1:0]                 n_c;
    logic                       fresh_c;
    logic [7:0]                 c;
    logic                       last_c;
    logic [34:0]                prod_c;
    logic [15:0]                pos_rep, past_rep;
    logic                       in_xfer, out_xfer;
    fel_pkg::lex_result_t       head;

    assign c        = s_tdata;
    assign last_c   = s_tlast;
    assign s_tready = (count_reg < 3'd3);
    assign in_xfer  = s_tvalid && s_tready;
    assign m_tvalid = (count_reg != 3'd0);
    assign out_xfer = m_tvalid && m_tready;

    assign pos_rep  = rep_pos(pos_reg);
    assign past_rep = rep_pos((pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1);
    assign prod_c   = (35'(acc_reg) << 3) + (35'(acc_reg) << 1) + 35'(4'(c - fel_pkg::CH_ZERO));

    always_comb
    begin
        mode_next    = mode_reg;
        acc_next     = acc_reg;
        ovf_next     = ovf_reg;
        ovf_pos_next = ovf_pos_reg;
        sso_next     = sso_reg;
        fresh_c      = 1'b0;
        n_c          = 2'd0;
        res_c[0]     = '0;
        res_c[1]     = '0;

        unique case (mode_reg)
            fel_pkg::MODE_HALT:
            begin
                fresh_c = 1'b0;
            end
            fel_pkg::MODE_INT:
            begin
                if (fel_pkg::is_digit(c))
                begin
                    if (prod_c > fel_pkg::INT_LIMIT)
                    begin
                        if (!ovf_reg)
                        begin
                            ovf_pos_next = pos_rep;
                        end
                        ovf_next = 1'b1;
                        acc_next = 32'h8000_0000;
                    end
                    else
                    begin
                        acc_next = prod_c[31:0];
                    end
                    if (last_c)
                    begin
                        res_c[n_c[0]] = fel_pkg::int_end_res(acc_next, ovf_next, ovf_pos_next);
                        n_c = n_c + 2'd1;
                    end
                end
                else
                begin
                    res_c[n_c[0]] = fel_pkg::int_end_res(acc_reg, ovf_reg, ovf_pos_reg);
                    n_c = n_c + 2'd1;
                    fresh_c = 1'b1;
                end
            end
            fel_pkg::MODE_IDENT:
            begin
                if (fel_pkg::is_alpha(c) || fel_pkg::is_digit(c))
                begin
                    res_c[n_c[0]] = fel_pkg::mk_res(fel_pkg::TT_IDENT, c, 1'b1, 1'b0, last_c,
                                                    31'd0, fel_pkg::ERR_NONE, 16'd0);
                    n_c = n_c + 2'd1;
                end
                else
                begin
                    res_c[n_c[0]] = fel_pkg::mk_res(fel_pkg::TT_IDENT, 8'd0, 1'b0, 1'b0, 1'b1,
                                                    31'd0, fel_pkg::ERR_NONE, 16'd0);
                    n_c = n_c + 2'd1;
                    fresh_c = 1'b1;
                end
            end
            fel_pkg::MODE_CMP:
            begin
                if (c == fel_pkg::CH_EQ)
                begin
                    res_c[n_c[0]] = fel_pkg::mk_res(fel_pkg::TT_OP, c, 1'b1, 1'b0, 1'b1,
                                                    31'd0, fel_pkg::ERR_NONE, 16'd0);
                    n_c = n_c + 2'd1;
                    mode_next = fel_pkg::MODE_IDLE;
                end
                else
                begin
                    res_c[n_c[0]] = fel_pkg::mk_res(fel_pkg::TT_OP, 8'd0, 1'b0, 1'b0, 1'b1,
                                                    31'd0, fel_pkg::ERR_NONE, 16'd0);
                    n_c = n_c + 2'd1;
                    fresh_c = 1'b1;
                end
            end
            fel_pkg::MODE_STR:
            begin
                if (c == fel_pkg::CH_QUOTE)
                begin
                    res_c[n_c[0]] = fel_pkg::mk_res(fel_pkg::TT_STR, 8'd0, 1'b0, !sso_reg, 1'b1,
                                                    31'd0, fel_pkg::ERR_NONE, 16'd0);
                    n_c = n_c + 2'd1;
                    mode_next = fel_pkg::MODE_IDLE;
                end
                else if (c == fel_pkg::CH_BSLASH)
                begin
                    mode_next = fel_pkg::MODE_ESC;
                end
                else
                begin
                    res_c[n_c[0]] = fel_pkg::mk_res(fel_pkg::TT_STR, c, 1'b1, !sso_reg, 1'b0,
                                                    31'd0, fel_pkg::ERR_NONE, 16'd0);
                    n_c = n_c + 2'd1;
                    sso_next = 1'b1;
                end
                if (last_c && (mode_next != fel_pkg::MODE_IDLE))
                begin
                    res_c[n_c[0]] = fel_pkg::mk_res(fel_pkg::TT_INT, 8'd0, 1'b0, 1'b0, 1'b0,
                                                    31'd0, fel_pkg::ERR_STR_EOT, past_rep);
                    n_c = n_c + 2'd1;
                    mode_next = fel_pkg::MODE_HALT;
                end
            end
            fel_pkg::MODE_ESC:
            begin
                if ((c == fel_pkg::CH_BSLASH) || (c == fel_pkg::CH_QUOTE))
                begin
                    res_c[n_c[0]] = fel_pkg::mk_res(fel_pkg::TT_STR, c, 1'b1, !sso_reg, 1'b0,
                                                    31'd0, fel_pkg::ERR_NONE, 16'd0);
                    n_c = n_c + 2'd1;
                    sso_next = 1'b1;
                    mode_next = fel_pkg::MODE_STR;
                    if (last_c)
                    begin
                        res_c[n_c[0]] = fel_pkg::mk_res(fel_pkg::TT_INT, 8'd0, 1'b0, 1'b0, 1'b0,
                                                        31'd0, fel_pkg::ERR_STR_EOT, past_rep);
                        n_c = n_c + 2'd1;
                        mode_next = fel_pkg::MODE_HALT;
                    end
                end
                else
                begin
                    res_c[n_c[0]] = fel_pkg::mk_res(fel_pkg::TT_INT, 8'd0, 1'b0, 1'b0, 1'b0,
                                                    31'd0, fel_pkg::ERR_CHAR, pos_rep);
                    n_c = n_c + 2'd1;
                    mode_next = fel_pkg::MODE_HALT;
                end
            end
            default:
            begin
                fresh_c = 1'b1;
            end
        endcase

        if (fresh_c)
        begin
            mode_next = fel_pkg::MODE_IDLE;
            if (fel_pkg::is_digit(c))
            begin
                acc_next     = 32'(4'(c - fel_pkg::CH_ZERO));
                ovf_next     = 1'b0;
                ovf_pos_next = 16'd0;
                mode_next    = fel_pkg::MODE_INT;
                if (last_c)
                begin
                    res_c[n_c[0]] = fel_pkg::int_end_res(acc_next, 1'b0, 16'd0);
                    n_c = n_c + 2'd1;
                end
            end
            else if (fel_pkg::is_alpha(c))
            begin
                res_c[n_c[0]] = fel_pkg::mk_res(fel_pkg::TT_IDENT, c, 1'b1, 1'b1, last_c,
                                                31'd0, fel_pkg::ERR_NONE, 16'd0);
                n_c = n_c + 2'd1;
                mode_next = fel_pkg::MODE_IDENT;
            end
            else if (c == fel_pkg::CH_QUOTE)
            begin
                sso_next  = 1'b0;
                mode_next = fel_pkg::MODE_STR;
                if (last_c)
                begin
                    res_c[n_c[0]] = fel_pkg::mk_res(fel_pkg::TT_INT, 8'd0, 1'b0, 1'b0, 1'b0,
                                                    31'd0, fel_pkg::ERR_STR_EOT, past_rep);
                    n_c = n_c + 2'd1;
                    mode_next = fel_pkg::MODE_HALT;
                end
            end
            else if ((c == fel_pkg::CH_LT) || (c == fel_pkg::CH_GT))
            begin
                res_c[n_c[0]] = fel_pkg::mk_res(fel_pkg::TT_OP, c, 1'b1, 1'b1, last_c,
                                                31'd0, fel_pkg::ERR_NONE, 16'd0);
                n_c = n_c + 2'd1;
                mode_next = fel_pkg::MODE_CMP;
            end
            else if (c inside {fel_pkg::CH_EQ, fel_pkg::CH_TILDE, fel_pkg::CH_PIPE,
                               fel_pkg::CH_AMP, fel_pkg::CH_LPAREN, fel_pkg::CH_RPAREN})
            begin
                res_c[n_c[0]] = fel_pkg::mk_res(fel_pkg::TT_OP, c, 1'b1, 1'b1, 1'b1,
                                                31'd0, fel_pkg::ERR_NONE, 16'd0);
                n_c = n_c + 2'd1;
            end
            else if (!fel_pkg::is_space(c))
            begin
                res_c[n_c[0]] = fel_pkg::mk_res(fel_pkg::TT_INT, 8'd0, 1'b0, 1'b0, 1'b0,
                                                31'd0, fel_pkg::ERR_CHAR, pos_rep);
                n_c = n_c + 2'd1;
                mode_next = fel_pkg::MODE_HALT;
            end
        end

        if (n_c != 2'd0)
        begin
            res_c[1'(n_c - 2'd1)].last_result = 1'b1;
        end

        if (last_c)
        begin
            mode_next    = fel_pkg::MODE_IDLE;
            acc_next     = 32'd0;
            ovf_next     = 1'b0;
            ovf_pos_next = 16'd0;
            sso_next     = 1'b0;
            pos_next     = '0;
        end
        else if (pos_reg != POS_MAX)
        begin
            pos_next = pos_reg + 1'b1;
        end
        else
        begin
            pos_next = pos_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= fel_pkg::MODE_IDLE;
            acc_reg     <= 32'd0;
            ovf_reg     <= 1'b0;
            ovf_pos_reg <= 16'd0;
            sso_reg     <= 1'b0;
            pos_reg     <= '0;
        end
        else if (in_xfer)
        begin
            mode_reg    <= mode_next;
            acc_reg     <= acc_next;
            ovf_reg     <= ovf_next;
            ovf_pos_reg <= ovf_pos_next;
            sso_reg     <= sso_next;
            pos_reg     <= pos_next;
        end
    end

    // result queue
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            if (n_c != 2'd0)
            begin
                fifo_reg[wr_ptr_reg] <= res_c[0];
            end
            if (n_c == 2'd2)
            begin
                fifo_reg[wr_ptr_reg + 2'd1] <= res_c[1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            if (in_xfer)
            begin
                wr_ptr_reg <= wr_ptr_reg + n_c;
            end
            if (out_xfer)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_reg + (in_xfer ? 3'(n_c) : 3'd0) - (out_xfer ? 3'd1 : 3'd0);
        end
    end

    assign head    = fifo_reg[rd_ptr_reg];
    assign m_tdata = {5'd0, head.error_position, head.error_code, head.int_value,
                      head.token_end, head.token_first, head.token_char};
    assign m_tuser = {head.char_valid, head.token_type};
    assign m_tlast = head.last_result;

endmodule
